// ===== hw/rtl/animation_frame_sequencer_defines.svh =====
// Assertion macros used by the frame sequencer top level.
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define AFS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afs: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define AFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afs: next-cycle check failed");

`endif

// ===== hw/rtl/afs_pkg.sv =====
// Types and constants of the animation frame sequencer.
package afs_pkg;

  // Payload widths
  localparam int OPCODE_W   = 3;
  localparam int ELAPSED_W  = 16;
  localparam int FRAME_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 9;
  localparam int PERIOD_W   = 16;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_START  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RESUME = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RESET  = 3'd4;

  // Play modes
  localparam logic [MODE_W-1:0] MODE_ONCE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PP      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PP_ONCE = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  // Register reset values
  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_LOOP;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the accepted beat
    logic step;   // subtract one period, advance one frame
    logic emit;   // load the result register
  } afs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;   // a whole period is still held during a tick
  } afs_stat_t;

endpackage

// ===== hw/rtl/afs_item_if.sv =====
// Input item channel: opcode and elapsed time.
interface afs_item_if import afs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, opcode, elapsed, input ready);
  modport sink (input valid, opcode, elapsed, output ready);
endinterface

// ===== hw/rtl/afs_result_if.sv =====
// Result channel: frame index and play flags.
interface afs_result_if import afs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_index;
  logic               playing;
  logic               reversing;

  modport source (output valid, frame_index, playing, reversing, input ready);
  modport sink (input valid, frame_index, playing, reversing, output ready);
endinterface

// ===== hw/rtl/afs_cfg_if.sv =====
// Configuration write channel: register index and data.
interface afs_cfg_if import afs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/afs_ctrl.sv =====
// Sequencer controller: accepts a beat, steps the frame loop, issues the result.
module afs_ctrl import afs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  afs_stat_t stat,
  output afs_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.more) begin
          cmd.step = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // result register free or being drained this cycle
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/afs_dp.sv =====
// Sequencer datapath: config registers, time accumulator, frame state, result register.
module afs_dp import afs_pkg::*; #(
  parameter int MAX_FRAMES = 256,
  parameter int TIME_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OPCODE_W-1:0]   opcode,
  input  logic [ELAPSED_W-1:0]  elapsed,
  input  afs_cmd_t              cmd,
  output afs_stat_t             stat,
  output logic [FRAME_W-1:0]    frame_index,
  output logic                  playing,
  output logic                  reversing
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int TW = TIME_BITS;
  localparam int AW = TIME_BITS + 1;

  // Configuration
  logic [MODE_W-1:0]   play_mode;
  logic [COUNT_W-1:0]  frame_count;
  logic [PERIOD_W-1:0] frame_period;

  // Sequence state
  logic [AW-1:0] acc;
  logic [FW-1:0] cur;
  logic          rev;
  logic          run;
  logic          loop_pend;

  logic [TW-1:0]      period_eff;
  logic [TW-1:0]      elapsed_m;
  logic [COUNT_W-1:0] count_nz;
  logic [FW-1:0]      last;
  logic               at_last;
  logic               at_zero;
  logic [FW-1:0]      cur_adv;
  logic               rev_adv;
  logic               run_adv;

  // Effective period, elapsed and last frame
  always_comb begin
    elapsed_m  = TW'(elapsed);
    period_eff = TW'(frame_period);
    if (period_eff == '0) begin
      period_eff = TW'(1);
    end
    count_nz = (frame_count == '0) ? COUNT_W'(1) : frame_count;
    if (32'(count_nz) > 32'(MAX_FRAMES)) begin
      last = FW'(MAX_FRAMES - 1);
    end else begin
      last = FW'(count_nz - COUNT_W'(1));
    end
  end

  assign stat.more = loop_pend && (acc >= AW'(period_eff));

  // One frame advance by play mode
  always_comb begin
    cur_adv = cur;
    rev_adv = rev;
    run_adv = run;
    at_last = (cur >= last);
    at_zero = (cur == '0);
    case (play_mode)
      MODE_ONCE: begin
        if (!at_last) cur_adv = cur + FW'(1);
        else          run_adv = 1'b0;
      end
      MODE_LOOP: begin
        cur_adv = at_last ? '0 : cur + FW'(1);
      end
      MODE_PP: begin
        if (!rev) begin
          if (!at_last) begin
            cur_adv = cur + FW'(1);
          end else begin
            rev_adv = 1'b1;
            if (!at_zero) cur_adv = cur - FW'(1);
          end
        end else begin
          if (!at_zero) begin
            cur_adv = cur - FW'(1);
          end else begin
            rev_adv = 1'b0;
            if (!at_last) cur_adv = cur + FW'(1);
          end
        end
      end
      MODE_PP_ONCE: begin
        if (!rev) begin
          if (!at_last) begin
            cur_adv = cur + FW'(1);
          end else begin
            rev_adv = 1'b1;
            if (!at_zero) cur_adv = cur - FW'(1);
          end
        end else begin
          if (!at_zero) cur_adv = cur - FW'(1);
          else          run_adv = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Config and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode    <= MODE_RST;
      frame_count  <= COUNT_RST;
      frame_period <= PERIOD_RST;
      acc          <= '0;
      cur          <= '0;
      rev          <= 1'b0;
      run          <= 1'b1;
      loop_pend    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   play_mode    <= cfg_data[MODE_W-1:0];
          REG_COUNT:  frame_count  <= cfg_data[COUNT_W-1:0];
          REG_PERIOD: frame_period <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        loop_pend <= (opcode == OP_TICK) && run;
        case (opcode)
          OP_TICK: begin
            if (run) acc <= acc + AW'(elapsed_m);
          end
          OP_START: begin
            acc <= '0;
            cur <= '0;
            rev <= 1'b0;
            run <= 1'b1;
          end
          OP_STOP:   run <= 1'b0;
          OP_RESUME: run <= 1'b1;
          OP_RESET: begin
            acc <= '0;
            cur <= '0;
            rev <= 1'b0;
            run <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.step) begin
        acc <= acc - AW'(period_eff);
        cur <= cur_adv;
        rev <= rev_adv;
        run <= run_adv;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame_index <= FRAME_W'(cur);
      playing     <= run;
      reversing   <= rev;
    end
  end

endmodule

// ===== hw/rtl/animation_frame_sequencer.sv =====
// Top level of the animation frame sequencer.
// Channels: item (opcode, elapsed) in, result (frame_index, playing, reversing)
// out, cfg (index, data) register writes; a beat moves when valid and ready are
// both high. Every item beat gives exactly one result beat: the state after it.
// A tick while playing adds elapsed to the time accumulator; the datapath then
// subtracts one frame period and advances the frame once per cycle until less
// than a period is held. Start and reset clear the accumulator; stop and resume
// change no time. The item is loaded in the idle state; the run state steps once
// per whole period consumed (none for commands and stopped ticks); the emit state
// then writes the result register, whose valid flag is registered. One item is
// worked at a time; the next is taken only after the frame advance loop and the result write.
// The result register decouples the sides: a new item is taken while the last
// result waits; a stalled receiver holds the block only when the next result
// is ready to be written.
// Config writes are always accepted and must happen while the block is idle.
// Reset (rst, synchronous): loop mode, one frame, period 1000, frame 0, forward,
// playing, result channel empty.
`include "animation_frame_sequencer_defines.svh"

module animation_frame_sequencer import afs_pkg::*; #(
  parameter int MAX_FRAMES = 256,
  parameter int TIME_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  afs_item_if.sink     item,
  afs_result_if.source result,
  afs_cfg_if.sink      cfg
);

  afs_cmd_t  cmd;
  afs_stat_t stat;

  assign cfg.ready = 1'b1;

  afs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  afs_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .opcode      (item.opcode),
    .elapsed     (item.elapsed),
    .cmd         (cmd),
    .stat        (stat),
    .frame_index (result.frame_index),
    .playing     (result.playing),
    .reversing   (result.reversing)
  );

  // Checks
  `AFS_ASSERT_NEXT(a_one_item, clk, rst, item.valid && item.ready, !item.ready)
  `AFS_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, result.valid)
  `AFS_ASSERT_SAME(a_step_busy, clk, rst, cmd.step, !item.ready && !cmd.emit)

endmodule
